>>> sv/ddrm_pkg.sv
// Shared types and constants for the differential drive ramped motor command block.
// Used by every module of the block; depends on nothing else.
package ddrm_pkg;

   // Item kinds carried on the request tuser.
   typedef enum logic [1:0] {
      FUNC_MOVE = 2'd0,
      FUNC_STOP = 2'd1,
      FUNC_TICK = 2'd2,
      FUNC_BAD  = 2'd3
   } func_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_CMD_TIMEOUT    = 3'd0;
   localparam logic [2:0] CSR_CONTROL_PERIOD = 3'd1;
   localparam logic [2:0] CSR_RAMP_STEP      = 3'd2;
   localparam logic [2:0] CSR_MIN_MOTOR      = 3'd3;
   localparam logic [2:0] CSR_PWM_MAX        = 3'd4;

   // Register values after reset.
   localparam logic [15:0] RST_CMD_TIMEOUT    = 16'd300;
   localparam logic [7:0]  RST_CONTROL_PERIOD = 8'd10;
   localparam logic [6:0]  RST_RAMP_STEP      = 7'd8;
   localparam logic [6:0]  RST_MIN_MOTOR      = 7'd60;
   localparam logic [15:0] RST_PWM_MAX        = 16'd2560;

   // Full scale of every percent value.
   localparam int PCT_LIMIT = 100;

   // x / 100 == (x * RECIP_MULT) >> RECIP_SHIFT for every x below 2**23.
   localparam int          RECIP_SHIFT = 30;
   localparam logic [23:0] RECIP_MULT  = 24'd10737419;

   typedef struct packed {
      logic [15:0] cmd_timeout;
      logic [7:0]  control_period;
      logic [6:0]  ramp_step;
      logic [6:0]  min_motor;
      logic [15:0] pwm_max;
   } cfg_type;

   // Clamped wheel levels and flags of one item, handed to the scaling pipeline.
   typedef struct packed {
      logic       update;
      logic       error;
      logic       left_neg;
      logic [6:0] left_mag;
      logic       right_neg;
      logic [6:0] right_mag;
   } level_type;

   typedef struct packed {
      logic        update;
      logic        error;
      logic        left_dir_fwd;
      logic        right_dir_pin;
      logic [15:0] left_compare;
      logic [15:0] right_compare;
   } result_type;

endpackage

>>> sv/ddrm_csr.sv
// Configuration registers of the motor command block.
// Depends on ddrm_pkg for register indexes, reset values and cfg_type.
module ddrm_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [2:0]        wr_index,
   input  logic [15:0]       wr_data,
   output ddrm_pkg::cfg_type cfg
);

   ddrm_pkg::cfg_type cfg_ff;
   ddrm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            ddrm_pkg::CSR_CMD_TIMEOUT:    cfg_in.cmd_timeout    = wr_data;
            ddrm_pkg::CSR_CONTROL_PERIOD: cfg_in.control_period = wr_data[7:0];
            ddrm_pkg::CSR_RAMP_STEP:      cfg_in.ramp_step      = wr_data[6:0];
            ddrm_pkg::CSR_MIN_MOTOR:      cfg_in.min_motor      = wr_data[6:0];
            ddrm_pkg::CSR_PWM_MAX:        cfg_in.pwm_max        = wr_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cmd_timeout    <= ddrm_pkg::RST_CMD_TIMEOUT;
         cfg_ff.control_period <= ddrm_pkg::RST_CONTROL_PERIOD;
         cfg_ff.ramp_step      <= ddrm_pkg::RST_RAMP_STEP;
         cfg_ff.min_motor      <= ddrm_pkg::RST_MIN_MOTOR;
         cfg_ff.pwm_max        <= ddrm_pkg::RST_PWM_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/ddrm_ctrl.sv
// Command, timeout and ramp state of the motor command block: one read-modify-write per word.
// Depends on ddrm_pkg for func_type, cfg_type, level_type and PCT_LIMIT.
module ddrm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  ddrm_pkg::func_type  func,
   input  logic signed [7:0]   fwd_demand,
   input  logic signed [7:0]   turn_demand,
   input  ddrm_pkg::cfg_type   cfg,
   output ddrm_pkg::level_type level
);

   localparam logic signed [8:0] LIM = 9'(ddrm_pkg::PCT_LIMIT);

   logic signed [7:0] left_target_ff,  left_target_in;
   logic signed [7:0] right_target_ff, right_target_in;
   logic signed [7:0] left_actual_ff,  left_actual_in;
   logic signed [7:0] right_actual_ff, right_actual_in;
   logic [15:0]       since_cmd_ff,    since_cmd_in;
   logic [7:0]        since_ctl_ff,    since_ctl_in;

   logic signed [7:0] fwd_sat, turn_sat;
   logic [15:0]       since_cmd_inc;
   logic [7:0]        since_ctl_inc;
   logic signed [7:0] tick_left_tgt, tick_right_tgt;
   logic              update, error;

   function automatic logic signed [7:0] sat_pct(input logic signed [8:0] v);
      logic signed [7:0] r;
      if (v > LIM) r = LIM[7:0];
      else if (v < -LIM) r = -LIM[7:0];
      else r = v[7:0];
      return r;
   endfunction

   // Any nonzero target gets at least the minimum magnitude, keeping its sign.
   function automatic logic signed [7:0] raise_min(input logic signed [7:0] v,
                                                    input logic [6:0] m);
      logic [7:0]        mag;
      logic signed [7:0] ms;
      logic signed [7:0] r;
      mag = v[7] ? 8'(-v) : 8'(v);
      ms  = $signed({1'b0, m});
      if (v == 8'sd0) r = 8'sd0;
      else if (mag < {1'b0, m}) r = v[7] ? -ms : ms;
      else r = v;
      return r;
   endfunction

   function automatic logic signed [7:0] slew(input logic signed [7:0] cur,
                                               input logic signed [7:0] tgt,
                                               input logic [6:0] step);
      logic signed [9:0] c, t, s;
      c = {{2{cur[7]}}, cur};
      t = {{2{tgt[7]}}, tgt};
      if (cur < tgt) begin
         s = c + $signed({3'b000, step});
         if (s > t) s = t;
      end else if (cur > tgt) begin
         s = c - $signed({3'b000, step});
         if (s < t) s = t;
      end else begin
         s = c;
      end
      return s[7:0];
   endfunction

   function automatic logic [6:0] clamp_mag(input logic signed [7:0] v);
      logic [7:0] mag;
      mag = v[7] ? 8'(-v) : 8'(v);
      if (mag > LIM[7:0]) mag = LIM[7:0];
      return mag[6:0];
   endfunction

   always_comb begin
      fwd_sat  = sat_pct({fwd_demand[7], fwd_demand});
      turn_sat = sat_pct({turn_demand[7], turn_demand});

      since_cmd_inc = (since_cmd_ff == 16'hFFFF) ? since_cmd_ff : since_cmd_ff + 16'd1;
      since_ctl_inc = (since_ctl_ff == 8'hFF) ? since_ctl_ff : since_ctl_ff + 8'd1;

      // A timeout zeroes the targets before this tick's ramp step uses them.
      if (since_cmd_inc > cfg.cmd_timeout) begin
         tick_left_tgt  = 8'sd0;
         tick_right_tgt = 8'sd0;
      end else begin
         tick_left_tgt  = left_target_ff;
         tick_right_tgt = right_target_ff;
      end

      left_target_in  = left_target_ff;
      right_target_in = right_target_ff;
      left_actual_in  = left_actual_ff;
      right_actual_in = right_actual_ff;
      since_cmd_in    = since_cmd_ff;
      since_ctl_in    = since_ctl_ff;
      update          = 1'b0;
      error           = 1'b0;

      if (accept) begin
         case (func)
            ddrm_pkg::FUNC_MOVE: begin
               left_target_in  = raise_min(sat_pct({fwd_sat[7], fwd_sat} +
                                                   {turn_sat[7], turn_sat}), cfg.min_motor);
               right_target_in = raise_min(sat_pct({fwd_sat[7], fwd_sat} -
                                                   {turn_sat[7], turn_sat}), cfg.min_motor);
               since_cmd_in    = 16'd0;
            end
            ddrm_pkg::FUNC_STOP: begin
               left_target_in  = 8'sd0;
               right_target_in = 8'sd0;
               since_cmd_in    = 16'd0;
            end
            ddrm_pkg::FUNC_TICK: begin
               since_cmd_in    = since_cmd_inc;
               left_target_in  = tick_left_tgt;
               right_target_in = tick_right_tgt;
               since_ctl_in    = since_ctl_inc;
               if (since_ctl_inc >= cfg.control_period) begin
                  since_ctl_in    = 8'd0;
                  left_actual_in  = slew(left_actual_ff, tick_left_tgt, cfg.ramp_step);
                  right_actual_in = slew(right_actual_ff, tick_right_tgt, cfg.ramp_step);
                  update          = 1'b1;
               end
            end
            default: begin
               error = 1'b1;
            end
         endcase
      end

      level.update    = update;
      level.error     = error;
      level.left_neg  = left_actual_in[7];
      level.left_mag  = clamp_mag(left_actual_in);
      level.right_neg = right_actual_in[7];
      level.right_mag = clamp_mag(right_actual_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_target_ff  <= 8'sd0;
         right_target_ff <= 8'sd0;
         left_actual_ff  <= 8'sd0;
         right_actual_ff <= 8'sd0;
         since_cmd_ff    <= 16'd0;
         since_ctl_ff    <= 8'd0;
      end else begin
         left_target_ff  <= left_target_in;
         right_target_ff <= right_target_in;
         left_actual_ff  <= left_actual_in;
         right_actual_ff <= right_actual_in;
         since_cmd_ff    <= since_cmd_in;
         since_ctl_ff    <= since_ctl_in;
      end
   end

   // A move or stop restarts the command timer.
   assert property (@(posedge clock) disable iff (reset)
      accept && (func == ddrm_pkg::FUNC_MOVE || func == ddrm_pkg::FUNC_STOP)
      |=> since_cmd_ff == 16'd0)
      else $error("command timer not cleared by a move or stop");

   // The wheel levels move only on a tick that ends a control period.
   assert property (@(posedge clock) disable iff (reset)
      !update |=> $stable(left_actual_ff) && $stable(right_actual_ff))
      else $error("actual level changed outside a control period");

   // Ending a control period restarts the period counter.
   assert property (@(posedge clock) disable iff (reset)
      update |=> since_ctl_ff == 8'd0)
      else $error("control period counter not restarted");

endmodule

>>> sv/ddrm_scale.sv
// PWM scaling pipeline: level register, pwm_max multiply, divide by 100, result register.
// Depends on ddrm_pkg for level_type, result_type and the reciprocal constants.
module ddrm_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  ddrm_pkg::level_type  level,
   input  logic [15:0]          pwm_max,
   output logic                 out_valid,
   output ddrm_pkg::result_type result
);

   localparam int QLO = ddrm_pkg::RECIP_SHIFT;
   localparam int QHI = ddrm_pkg::RECIP_SHIFT + 15;

   // Stage A: levels of the accepted word.
   logic                lvl_valid_ff;
   ddrm_pkg::level_type lvl_ff;

   // Stage B: products pwm_max * magnitude.
   logic        prod_valid_ff;
   logic        prod_update_ff, prod_error_ff, prod_left_dir_ff, prod_right_dir_ff;
   logic [22:0] left_prod_ff, right_prod_ff;
   logic [22:0] left_prod_in, right_prod_in;

   // Stage C: result register.
   logic                 res_valid_ff;
   ddrm_pkg::result_type res_ff;
   ddrm_pkg::result_type res_in;

   function automatic logic [15:0] div100(input logic [22:0] x);
      logic [46:0] p;
      p = 47'(x) * 47'(ddrm_pkg::RECIP_MULT);
      return p[QHI:QLO];
   endfunction

   assign left_prod_in  = 23'(pwm_max) * 23'(lvl_ff.left_mag);
   assign right_prod_in = 23'(pwm_max) * 23'(lvl_ff.right_mag);

   always_comb begin
      res_in.update        = prod_update_ff;
      res_in.error         = prod_error_ff;
      res_in.left_dir_fwd  = prod_left_dir_ff;
      res_in.right_dir_pin = prod_right_dir_ff;
      res_in.left_compare  = div100(left_prod_ff);
      res_in.right_compare = div100(right_prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else if (enable) begin
         lvl_valid_ff  <= in_valid;
         prod_valid_ff <= lvl_valid_ff;
         res_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lvl_ff            <= level;
         prod_update_ff    <= lvl_ff.update;
         prod_error_ff     <= lvl_ff.error;
         prod_left_dir_ff  <= !lvl_ff.left_neg;
         prod_right_dir_ff <= lvl_ff.right_neg;
         left_prod_ff      <= left_prod_in;
         right_prod_ff     <= right_prod_in;
         res_ff            <= res_in;
      end
   end

   assign out_valid = res_valid_ff;
   assign result    = res_ff;

   // A word is either a tick or a malformed command, never both.
   assert property (@(posedge clock) disable iff (reset)
      res_valid_ff |-> !(res_ff.update && res_ff.error))
      else $error("result flags both a refresh and an error");

   // A zero magnitude must scale to a zero compare value.
   assert property (@(posedge clock) disable iff (reset)
      enable && prod_valid_ff && left_prod_ff == 23'd0 |=> res_ff.left_compare == 16'd0)
      else $error("zero product gave a nonzero left compare value");

endmodule

>>> sv/diff_drive_ramped_motor_command_top.sv
// Channel   Dir  Payload (low bit first)                                    Handshake
// req_      in   tdata: fwd_demand[7:0], turn_demand[15:8]; tuser: func[1:0] tvalid/tready
// rsp_      out  tdata: left_dir_fwd, right_dir_pin, left_compare,           tvalid/tready
//                right_compare; tuser: pwm_update[0], cmd_error[1]
// csr_      in   csr_index[2:0], csr_data[15:0]                               valid/ready
//
// One word is accepted per cycle unless the result is stalled; its result passes through
// the level register, pwm_max multiply and divide-by-100 multiply into the result register.
// The command, timeout and ramp state update in the cycle the word is accepted.
// Reset loads the register defaults and zeroes all targets, levels and timers.
// A stalled result freezes the whole pipeline and drops req_tready in the same cycle.
// Configuration writes are always accepted and take effect on the next cycle.
module diff_drive_ramped_motor_command_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // fwd_demand[7:0], turn_demand[15:8]
   input  logic [1:0]  req_tuser,   // func[1:0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // left_dir_fwd[0], right_dir_pin[1], left_compare[17:2],
                                    // right_compare[33:18], zero[39:34]
   output logic [1:0]  rsp_tuser,   // pwm_update[0], cmd_error[1]

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   ddrm_pkg::cfg_type    cfg;
   ddrm_pkg::level_type  level;
   ddrm_pkg::result_type result;
   logic                 enable;
   logic                 accept;
   logic                 out_valid;

   // The pipeline moves whenever the result register is empty or being taken.
   assign enable     = !out_valid || rsp_tready;
   assign req_tready = enable;
   assign accept     = req_tvalid && enable;
   assign csr_ready  = 1'b1;

   ddrm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   ddrm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (ddrm_pkg::func_type'(req_tuser)),
      .fwd_demand  ($signed(req_tdata[7:0])),
      .turn_demand ($signed(req_tdata[15:8])),
      .cfg         (cfg),
      .level       (level)
   );

   ddrm_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (accept),
      .level     (level),
      .pwm_max   (cfg.pwm_max),
      .out_valid (out_valid),
      .result    (result)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {6'd0, result.right_compare, result.left_compare,
                        result.right_dir_pin, result.left_dir_fwd};
   assign rsp_tuser  = {result.error, result.update};

endmodule
